// ===== rtl/wwt_pkg.sv =====
// ----------------------------------------------------------------------------
// wwt_pkg
// Shared constants and types for the windowed waypoint tracker.
// ----------------------------------------------------------------------------
package wwt_pkg;

	localparam int MAX_WAYPOINTS_DEF = 256;
	localparam int JOINTS_DEF        = 6;
	localparam int WINDOW_AHEAD_DEF  = 16;
	localparam int WINDOW_BEHIND_DEF = 2;

	localparam int IN_JOINTS = 6;   // joint ports on the top level
	localparam int POS_W     = 20;  // Q4.16 joint position
	localparam int DIFF_W    = POS_W + 1;
	localparam int SQ_W      = 2 * DIFF_W;
	localparam int SUM_W     = SQ_W + 3;  // room for up to eight joints
	localparam int TOL_W     = 16;
	localparam int SEG_W     = 8;
	localparam int PROG_W    = 17;
	localparam int FRAC_W    = 16;

	localparam logic [TOL_W-1:0]  TOL_RESET = 16'd655;
	localparam logic [PROG_W-1:0] ONE_Q16   = 17'h10000;

	typedef enum logic [1:0] {
		FUNC_CLEAR  = 2'd0,
		FUNC_APPEND = 2'd1,
		FUNC_SAMPLE = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	// tag that travels with a window element through the lanes
	typedef struct packed {
		logic vld;
		logic last;
	} scan_ctl_t;

endpackage

// ===== rtl/wwt_lane.sv =====
// ----------------------------------------------------------------------------
// wwt_lane
// One joint lane: waypoint memory for the joint, held sample, squared error.
// ----------------------------------------------------------------------------
module wwt_lane import wwt_pkg::*; #(
	parameter int MAX_WAYPOINTS = MAX_WAYPOINTS_DEF
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(MAX_WAYPOINTS)-1:0] waddr,
	input  logic                             ld,
	input  logic signed [POS_W-1:0]          pos,
	input  logic                             re,
	input  logic [$clog2(MAX_WAYPOINTS)-1:0] raddr,
	output logic [SQ_W-1:0]                  sq_s2
);

	logic signed [POS_W-1:0] mem [MAX_WAYPOINTS];
	logic signed [POS_W-1:0] rd_s1;
	logic signed [POS_W-1:0] sample_q;
	logic signed [DIFF_W-1:0] diff;
	logic signed [SQ_W-1:0]   prod;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= pos;
		end
		if (re) begin
			rd_s1 <= mem[raddr];
		end
		if (ld) begin
			sample_q <= pos;
		end
	end

	assign diff = DIFF_W'(sample_q) - DIFF_W'(rd_s1);

	// full-width square of the joint error
	assign prod = SQ_W'(diff) * SQ_W'(diff);

	always_ff @(posedge clk) begin
		sq_s2 <= unsigned'(prod);
	end

endmodule

// ===== rtl/wwt_merge.sv =====
// ----------------------------------------------------------------------------
// wwt_merge
// Sums lane results and keeps the nearest waypoint, stopping on a close hit.
// ----------------------------------------------------------------------------
module wwt_merge import wwt_pkg::*; #(
	parameter int JOINTS = JOINTS_DEF,
	parameter int IW     = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              init,
	input  scan_ctl_t         ctl,
	input  logic [IW-1:0]     idx,
	input  logic [SQ_W-1:0]   sq [JOINTS],
	input  logic [2*TOL_W-1:0] tol_sq,
	output logic              done,
	output logic [IW-1:0]     best
);

	logic [SUM_W-1:0] sum;
	logic [SUM_W-1:0] sum_s3;
	logic [IW-1:0]    idx_s3;
	scan_ctl_t        ctl_s3;
	logic [SUM_W-1:0] best_d_q;
	logic [IW-1:0]    best_q;
	logic             armed_q;
	logic             done_q;
	logic             lt;
	logic             hit;

	always_comb begin
		sum = '0;
		for (int j = 0; j < JOINTS; j++) begin
			sum = sum + SUM_W'(sq[j]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else begin
			ctl_s3.vld  <= ctl.vld & armed_q;
			ctl_s3.last <= ctl.last;
		end
	end

	always_ff @(posedge clk) begin
		sum_s3 <= sum;
		idx_s3 <= idx;
	end

	assign lt  = sum_s3 < best_d_q;
	assign hit = sum_s3 <= SUM_W'(tol_sq);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q  <= 1'b0;
			done_q   <= 1'b0;
			best_d_q <= '1;
			best_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (init) begin
				armed_q  <= 1'b1;
				best_d_q <= '1;
			end else if (armed_q && ctl_s3.vld) begin
				if (lt || hit) begin
					best_q <= idx_s3;
				end
				if (lt) begin
					best_d_q <= sum_s3;
				end
				if (hit || ctl_s3.last) begin
					armed_q <= 1'b0;
					done_q  <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign best = best_q;

endmodule

// ===== rtl/wwt_div.sv =====
// ----------------------------------------------------------------------------
// wwt_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wwt_div #(
	parameter int NW = 24,
	parameter int DW = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quot
);

	localparam int CNT_W = $clog2(NW + 1);

	logic [NW-1:0]    quot_q;
	logic [DW:0]      rem_q;
	logic [DW-1:0]    den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DW:0]      trial;
	logic             fits;

	assign trial = {rem_q[DW-1:0], quot_q[NW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quot_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (run_q) begin
			rem_q  <= fits ? trial - {1'b0, den_q} : trial;
			quot_q <= {quot_q[NW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ===== rtl/windowed_waypoint_tracker.sv =====
// ----------------------------------------------------------------------------
// windowed_waypoint_tracker
// Stores a joint-space trajectory and tracks the nearest waypoint to each
// measured joint vector inside a window around the last tracked index.
// ----------------------------------------------------------------------------
//
// channel   | ports                                         | handshake
// ----------+-----------------------------------------------+-----------------
// command   | func, segment_end, joint_pos_0..joint_pos_5   | start & !busy
// result    | closest_index, segment_number, progress,      | done, one cycle
//           | no_path                                       |
// config    | tol_wdata                                     | tol_we
//
// clear and append finish in the cycle they are accepted; busy stays low
// a sample walks n window elements one per cycle (n up to WINDOW_BEHIND +
// WINDOW_AHEAD, fewer on an early hit), the merge ends once the last one has
// passed the lane read, square, merge sum and merge done registers, then the
// progress divider works out log2(MAX_WAYPOINTS) + 16 quotient bits;
// done shows after the divider finishes and busy falls with it
// a sample with no waypoints loaded gives done in the cycle after start
// reset clears count, tracked index and segment and sets the tolerance to its
// default; memories are not cleared, only entries below the count are read
// the receiver cannot stall, so a result transaction never waits
// ----------------------------------------------------------------------------
module windowed_waypoint_tracker import wwt_pkg::*; #(
	parameter int MAX_WAYPOINTS = MAX_WAYPOINTS_DEF,
	parameter int JOINTS        = JOINTS_DEF,
	parameter int WINDOW_AHEAD  = WINDOW_AHEAD_DEF,
	parameter int WINDOW_BEHIND = WINDOW_BEHIND_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               func,
	input  logic                     segment_end,
	input  logic signed [POS_W-1:0]  joint_pos_0,
	input  logic signed [POS_W-1:0]  joint_pos_1,
	input  logic signed [POS_W-1:0]  joint_pos_2,
	input  logic signed [POS_W-1:0]  joint_pos_3,
	input  logic signed [POS_W-1:0]  joint_pos_4,
	input  logic signed [POS_W-1:0]  joint_pos_5,
	input  logic                     tol_we,
	input  logic [TOL_W-1:0]         tol_wdata,
	output logic                     done,
	output logic [7:0]               closest_index,
	output logic [SEG_W-1:0]         segment_number,
	output logic [PROG_W-1:0]        progress,
	output logic                     no_path
);

	localparam int IW = $clog2(MAX_WAYPOINTS);
	localparam int CW = IW + 1;          // count, can hold MAX_WAYPOINTS
	localparam int EW = CW + 7;          // window bound arithmetic
	localparam int NW = IW + FRAC_W;     // dividend of the progress ratio

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DIV  = 3'b100
	} state_t;

	state_t state_q;

	// registers and architectural state
	logic [TOL_W-1:0]   tol_q;
	logic [2*TOL_W-1:0] tol_sq_q;
	logic [CW-1:0]      count_q;
	logic [IW-1:0]      tracked_q;
	logic [SEG_W-1:0]   cur_seg_q;

	// window walk
	logic [CW-1:0] rd_idx_q;
	logic [CW-1:0] end_q;
	logic          issue;
	logic [IW-1:0] idx_s1;
	logic [IW-1:0] idx_s2;
	scan_ctl_t     ctl_s1;
	scan_ctl_t     ctl_s2;

	// command decode
	logic accept;
	logic do_clear;
	logic do_append;
	logic do_sample;
	logic [EW-1:0] win_lo;
	logic [EW-1:0] win_hi;
	logic [EW-1:0] trk_ext;

	// lane inputs and results
	logic signed [POS_W-1:0] pos_in [JOINTS];
	logic [SQ_W-1:0]         sq_s2 [JOINTS];

	// merge and divider status
	logic          m_done;
	logic [IW-1:0] m_best;
	logic          d_done;
	logic [NW-1:0] d_quot;

	// segment tags and results
	logic [SEG_W-1:0]  seg_mem [MAX_WAYPOINTS];
	logic [SEG_W-1:0]  seg_rd_q;
	logic [IW-1:0]     best_q;
	logic [IW+7:0]     best_ext;
	logic              done_q;
	logic [7:0]        idx_out_q;
	logic [SEG_W-1:0]  seg_out_q;
	logic [PROG_W-1:0] prog_out_q;
	logic              no_path_q;

	assign busy      = state_q != ST_IDLE;
	assign accept    = start && !busy;
	assign do_clear  = accept && func == FUNC_CLEAR;
	assign do_append = accept && func == FUNC_APPEND && count_q < CW'(MAX_WAYPOINTS);
	assign do_sample = accept && func == FUNC_SAMPLE;

	// joint ports into lanes; joints past the ports read as zero
	always_comb begin
		for (int j = 0; j < JOINTS; j++) begin
			case (j)
				0:       pos_in[j] = joint_pos_0;
				1:       pos_in[j] = joint_pos_1;
				2:       pos_in[j] = joint_pos_2;
				3:       pos_in[j] = joint_pos_3;
				4:       pos_in[j] = joint_pos_4;
				5:       pos_in[j] = joint_pos_5;
				default: pos_in[j] = '0;
			endcase
		end
	end

	// window bounds: [tracked - behind, tracked + ahead) clipped to [0, count)
	assign trk_ext = EW'(tracked_q);
	assign win_lo  = (trk_ext > EW'(WINDOW_BEHIND)) ? trk_ext - EW'(WINDOW_BEHIND) : '0;
	assign win_hi  = (trk_ext + EW'(WINDOW_AHEAD) > EW'(count_q)) ?
		EW'(count_q) : trk_ext + EW'(WINDOW_AHEAD);

	assign issue = state_q == ST_SCAN && rd_idx_q != end_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (tol_we) begin
			tol_q <= tol_wdata;
		end
	end

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			tracked_q <= '0;
			cur_seg_q <= '0;
			done_q    <= 1'b0;
			ctl_s1    <= '0;
			ctl_s2    <= '0;
			rd_idx_q  <= '0;
			end_q     <= '0;
		end else begin
			done_q <= 1'b0;
			ctl_s1.vld  <= issue;
			ctl_s1.last <= rd_idx_q == end_q - 1'b1;
			ctl_s2      <= ctl_s1;
			case (state_q)
				ST_IDLE: begin
					if (do_clear) begin
						count_q   <= '0;
						tracked_q <= '0;
						cur_seg_q <= '0;
					end
					if (do_append) begin
						count_q <= count_q + 1'b1;
						if (segment_end && cur_seg_q != '1) begin
							cur_seg_q <= cur_seg_q + 1'b1;
						end
					end
					if (do_sample) begin
						if (count_q == '0) begin
							// empty trajectory answers at once
							done_q <= 1'b1;
						end else begin
							rd_idx_q <= CW'(win_lo);
							end_q    <= CW'(win_hi);
							state_q  <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (issue) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (m_done) begin
						// advance the tracked index from the chosen waypoint
						if (m_best > tracked_q) begin
							tracked_q <= m_best;
						end else if (m_best == tracked_q &&
							CW'(tracked_q) + 1'b1 < count_q) begin
							tracked_q <= tracked_q + 1'b1;
						end
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (d_done) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload side of the sequencer
	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q[IW-1:0];
		idx_s2 <= idx_s1;
		if (do_sample) begin
			tol_sq_q <= tol_q * tol_q;
		end
		if (do_append) begin
			seg_mem[count_q[IW-1:0]] <= cur_seg_q;
		end
		if (m_done) begin
			seg_rd_q <= seg_mem[m_best];
			best_q   <= m_best;
		end
	end

	assign best_ext = {8'b0, best_q};

	// result registers
	always_ff @(posedge clk) begin
		if (do_sample && count_q == '0) begin
			idx_out_q  <= '0;
			seg_out_q  <= '0;
			prog_out_q <= '0;
			no_path_q  <= 1'b1;
		end else if (state_q == ST_DIV && d_done) begin
			idx_out_q  <= best_ext[7:0];
			seg_out_q  <= seg_rd_q;
			prog_out_q <= (d_quot > NW'(ONE_Q16)) ? ONE_Q16 : d_quot[PROG_W-1:0];
			no_path_q  <= 1'b0;
		end
	end

	// one lane per joint
	for (genvar j = 0; j < JOINTS; j++) begin : g_lane
		wwt_lane #(
			.MAX_WAYPOINTS(MAX_WAYPOINTS)
		) u_lane (
			.clk   (clk),
			.we    (do_append),
			.waddr (count_q[IW-1:0]),
			.ld    (do_sample),
			.pos   (pos_in[j]),
			.re    (issue),
			.raddr (rd_idx_q[IW-1:0]),
			.sq_s2 (sq_s2[j])
		);
	end

	wwt_merge #(
		.JOINTS(JOINTS),
		.IW    (IW)
	) u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.init   (do_sample),
		.ctl    (ctl_s2),
		.idx    (idx_s2),
		.sq     (sq_s2),
		.tol_sq (tol_sq_q),
		.done   (m_done),
		.best   (m_best)
	);

	wwt_div #(
		.NW(NW),
		.DW(CW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (m_done && state_q == ST_SCAN),
		.num    ({m_best, FRAC_W'(0)}),
		.den    (count_q),
		.done   (d_done),
		.quot   (d_quot)
	);

	assign done           = done_q;
	assign closest_index  = idx_out_q;
	assign segment_number = seg_out_q;
	assign progress       = prog_out_q;
	assign no_path        = no_path_q;

`ifndef ASSERT_OFF
	// a result never shows while a command is still at work
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");

	// tracked index stays inside the loaded trajectory
	a_tracked_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 |-> CW'(tracked_q) < count_q) else $error("tracked index out of range");

	// empty trajectory result carries zero fields
	a_no_path_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && no_path) |-> (closest_index == '0 && progress == '0 && segment_number == '0))
		else $error("no_path result with data");

	// a search leaves scan exactly when the merge stage finishes
	a_scan_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && m_done) |=> state_q == ST_DIV) else $error("scan exit lost");

	// progress never exceeds one
	a_prog_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> progress <= ONE_Q16) else $error("progress above one");
`endif

endmodule
